[src/mmae_pkg.sv]
// Package for the matrix multiply-add engine: operation and register codes,
// fixed field widths and the command and status structs between controller and datapath.
// Depends on nothing.
package mmae_pkg;

	localparam int DIM_W = 4;   // width of a dimension register
	localparam int IDX_W = 3;   // width of a row or column index
	localparam int VAL_W = 32;  // width of a matrix element
	localparam int CFG_AW = 3;  // width of the register index

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_RUN     = 2'd2;

	localparam logic [CFG_AW-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_ROWS_A = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_COLS_A = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_ROWS_B = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_COLS_B = 3'd4;

	localparam logic MODE_ADD = 1'b0;

	typedef struct packed {
		logic             wr_a;      // write the input word's element into A
		logic             wr_b;      // write it into B
		logic             issue;     // read one A/B pair into the MAC pipeline
		logic             first_k;   // first term of the current element
		logic             last_k;    // final term of the current element
		logic             add_mode;  // element-wise addition instead of product
		logic [IDX_W-1:0] idx_i;
		logic [IDX_W-1:0] idx_j;
		logic [IDX_W-1:0] idx_k;
		logic             load;      // load the output register
		logic             res_last;
		logic             res_err;
	} mmae_cmd_t;

	typedef struct packed {
		logic acc_done;  // accumulator holds a finished element
		logic out_free;  // output register can take a word this cycle
	} mmae_stat_t;

endpackage

[src/matrix_multiply_add_engine_top.sv]
// Top level of the matrix multiply-add engine: stream ports, configuration port,
// controller and datapath. Depends on mmae_pkg, mmae_ctrl and mmae_datapath.

// The engine holds two signed 32-bit matrices A and B of up to MAX_DIM by
// MAX_DIM elements, loaded one word at a time on the input stream, and on a
// run word streams out either their element-wise sum (mode 0) or their
// product (mode 1) in row-major order, each result with its row and column and
// the final one marked by tlast. Arithmetic wraps modulo 2^32. If the
// dimension registers do not fit the mode, or any is zero or above MAX_DIM,
// a run gives one word with tuser set, value, row and column zero and tlast
// set. Element writes are taken one per cycle while the engine is idle; a
// write with row or column at or above MAX_DIM is dropped, as is the unused
// operation code. A run occupies the engine: the single multiply-accumulate
// unit reads one A/B pair a cycle from the two element stores into its
// three-stage read, multiply and accumulate pipeline, one sum per result in
// addition mode. No input word is taken until the last result of a run has
// been loaded into the output register, and that register stalls the engine
// only while the previous result is still waiting. The element stores are
// not cleared; elements must be written before a run reads them.
// Configuration is written through cfg_we, cfg_addr and cfg_data; the user
// must do so only while the engine is idle; the block does not enforce it.
module matrix_multiply_add_engine_top import mmae_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,   // operation, row, col, value
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // result_value, result_row, result_col, zero pad
	output logic              m_axis_tlast,
	output logic              m_axis_tuser    // dim_error
);

	logic [1:0]       in_op;
	logic [IDX_W-1:0] in_row, in_col;
	logic [VAL_W-1:0] in_value;
	mmae_cmd_t        cmd;
	mmae_stat_t       stat;

	// Unpack the input word, lowest field first.
	assign in_op    = s_axis_tdata[1:0];
	assign in_row   = s_axis_tdata[4:2];
	assign in_col   = s_axis_tdata[7:5];
	assign in_value = s_axis_tdata[39:8];

	mmae_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op   (in_op),
		.in_row  (in_row),
		.in_col  (in_col),
		.cmd     (cmd),
		.stat    (stat)
	);

	mmae_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.wr_row   (in_row),
		.wr_col   (in_col),
		.wr_value (in_value),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast),
		.out_err  (m_axis_tuser)
	);

endmodule

[src/mmae_datapath.sv]
// Datapath of the matrix multiply-add engine: the two element stores, the
// multiply-accumulate pipeline and the output register. Depends on mmae_pkg.
module mmae_datapath import mmae_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mmae_cmd_t        cmd,
	output mmae_stat_t       stat,
	input  logic [IDX_W-1:0] wr_row,
	input  logic [IDX_W-1:0] wr_col,
	input  logic [VAL_W-1:0] wr_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [39:0]      out_data,   // result_value, result_row, result_col, zero pad
	output logic             out_last,
	output logic             out_err
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];

	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

	logic [VAL_W-1:0] rd_a_s1, rd_b_s1;
	logic             valid_s1, first_s1, last_s1, add_s1;
	logic [VAL_W-1:0] term_s2;
	logic             valid_s2, first_s2, last_s2;
	logic [VAL_W-1:0] acc_q;
	logic             acc_done_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic             out_last_q, out_err_q;
	logic             out_free;

	assign wr_addr = AW'(int'(wr_row) * MAX_DIM + int'(wr_col));
	assign rd_addr_a = cmd.add_mode ? AW'(int'(cmd.idx_i) * MAX_DIM + int'(cmd.idx_j))
	                                : AW'(int'(cmd.idx_i) * MAX_DIM + int'(cmd.idx_k));
	assign rd_addr_b = cmd.add_mode ? AW'(int'(cmd.idx_i) * MAX_DIM + int'(cmd.idx_j))
	                                : AW'(int'(cmd.idx_k) * MAX_DIM + int'(cmd.idx_j));

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= wr_value;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= wr_value;
		end
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1   <= cmd.issue;
			valid_s2   <= valid_s1;
			acc_done_q <= valid_s2 & last_s2;
		end
	end

	// Both sums and products keep only the low 32 bits.
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first_k;
		last_s1  <= cmd.last_k;
		add_s1   <= cmd.add_mode;
		term_s2  <= add_s1 ? (rd_a_s1 + rd_b_s1) : (rd_a_s1 * rd_b_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + term_s2;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && out_free) begin
			out_value_q <= cmd.res_err ? '0 : acc_q;
			out_row_q   <= cmd.res_err ? '0 : cmd.idx_i;
			out_col_q   <= cmd.res_err ? '0 : cmd.idx_j;
			out_last_q  <= cmd.res_last;
			out_err_q   <= cmd.res_err;
		end
	end

	assign stat.acc_done = acc_done_q;
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, out_col_q, out_row_q, out_value_q};
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

endmodule

[src/mmae_ctrl.sv]
// Controller of the matrix multiply-add engine: configuration registers,
// dimension check, element counters and the run sequencer. Depends on mmae_pkg.
module mmae_ctrl import mmae_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  logic [IDX_W-1:0]  in_row,
	input  logic [IDX_W-1:0]  in_col,
	output mmae_cmd_t         cmd,
	input  mmae_stat_t        stat
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic [1:0]       state_q, state_d;
	logic             mode_q;
	logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [IDX_W-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic             err_q, err_d;

	logic             accept, in_range, dims_ok;
	logic [DIM_W-1:0] out_cols;
	logic             last_k, last_j, last_i;

	function automatic logic dim_ok(input logic [DIM_W-1:0] d);
		return (d != '0) && (d <= DIM_MAX);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			rows_a_q <= DIM_W'(1);
			cols_a_q <= DIM_W'(1);
			rows_b_q <= DIM_W'(1);
			cols_b_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_COLS_A: cols_a_q <= cfg_data;
				CFG_ROWS_B: rows_b_q <= cfg_data;
				CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({1'b0, in_row} < DIM_MAX) && ({1'b0, in_col} < DIM_MAX);

	assign dims_ok = dim_ok(rows_a_q) && dim_ok(cols_a_q) && dim_ok(rows_b_q)
	                 && dim_ok(cols_b_q)
	                 && ((mode_q == MODE_ADD) ? (rows_a_q == rows_b_q && cols_a_q == cols_b_q)
	                                          : (cols_a_q == rows_b_q));

	assign out_cols = (mode_q == MODE_ADD) ? cols_a_q : cols_b_q;
	assign last_k = (mode_q == MODE_ADD) || (({1'b0, k_q} + DIM_W'(1)) == cols_a_q);
	assign last_j = ({1'b0, j_q} + DIM_W'(1)) == out_cols;
	assign last_i = ({1'b0, i_q} + DIM_W'(1)) == rows_a_q;

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		err_d   = err_q;

		cmd          = '0;
		cmd.add_mode = (mode_q == MODE_ADD);
		cmd.idx_i    = i_q;
		cmd.idx_j    = j_q;
		cmd.idx_k    = k_q;
		cmd.first_k  = (k_q == '0);
		cmd.last_k   = last_k;
		cmd.res_err  = err_q;
		cmd.res_last = err_q || (last_i && last_j);

		case (state_q)
			ST_IDLE: begin
				cmd.wr_a = accept && (in_op == OP_WRITE_A) && in_range;
				cmd.wr_b = accept && (in_op == OP_WRITE_B) && in_range;
				if (accept && in_op == OP_RUN) begin
					i_d   = '0;
					j_d   = '0;
					k_d   = '0;
					err_d = !dims_ok;
					state_d = dims_ok ? ST_ISSUE : ST_EMIT;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (last_k) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				if (stat.acc_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.load = 1'b1;
				if (stat.out_free) begin
					if (err_q || (last_i && last_j)) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ISSUE;
						if (last_j) begin
							j_d = '0;
							i_d = i_q + IDX_W'(1);
						end else begin
							j_d = j_q + IDX_W'(1);
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			err_q   <= err_d;
		end
	end

endmodule

[dv/matrix_multiply_add_engine_top_tb.sv]
// Self-checking testbench for matrix_multiply_add_engine_top: a directed table, then random
// phases of element loads and runs, all checked word by word against an in-bench predictor.
// Depends on mmae_pkg and the engine's top level.
`timescale 1ns / 1ps

module matrix_multiply_add_engine_top_tb;
	import mmae_pkg::*;

	localparam int MAX_DIM = 8;

	// The engine's package names the three operations it acts on; the fourth code is the one
	// it must drop, and the product mode is simply the other value of the mode bit.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic       MODE_MUL  = 1'b1;

	// Cycles allowed after the last expected word before the engine counts as idle; the
	// margin is generous.
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES   = 50;
	localparam int HOLD_CYCLES   = 300;

	// One output word as the engine presents it.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
		logic             err;
	} result_word_t;

	// One row of the directed table: either a register write or an input word.
	typedef struct {
		bit                is_cfg;
		logic [CFG_AW-1:0] cfg_idx;
		logic [DIM_W-1:0]  cfg_val;
		logic [1:0]        op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [VAL_W-1:0]  value;
		bit                typed_err;   // expected word is the error word, typed in
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [DIM_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata = '0;   // operation, row, col, value
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [39:0]       m_axis_tdata;        // result_value, result_row, result_col, zero pad
	logic              m_axis_tlast;
	logic              m_axis_tuser;        // dim_error

	matrix_multiply_add_engine_top #(
		.MAX_DIM(MAX_DIM)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor's own copy of the configuration and of both element stores. The written
	// flags keep every run away from entries that were never loaded, whose contents the
	// engine does not define.
	logic             eng_mode = MODE_MUL;
	logic [DIM_W-1:0] a_rows = 4'd1;
	logic [DIM_W-1:0] a_cols = 4'd1;
	logic [DIM_W-1:0] b_rows = 4'd1;
	logic [DIM_W-1:0] b_cols = 4'd1;
	logic [VAL_W-1:0] store_a [MAX_DIM*MAX_DIM];
	logic [VAL_W-1:0] store_b [MAX_DIM*MAX_DIM];
	bit               a_written [MAX_DIM*MAX_DIM];
	bit               b_written [MAX_DIM*MAX_DIM];

	result_word_t expected_words [$];
	stim_row_t    directed_rows [$];

	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit calm = 1'b0;        // both sides stop idling while set
	int hold_cnt = 0;
	bit hold_used = 1'b0;

	function automatic bit dim_in_range(input logic [DIM_W-1:0] d);
		return int'(d) >= 1 && int'(d) <= MAX_DIM;
	endfunction

	// True when the dimension registers suit the mode, so that a run gives elements rather
	// than the single error word.
	function automatic bit dims_fit();
		bit ok;
		ok = dim_in_range(a_rows) && dim_in_range(a_cols) &&
			dim_in_range(b_rows) && dim_in_range(b_cols);
		if (eng_mode == MODE_ADD) begin
			ok = ok && a_rows == b_rows && a_cols == b_cols;
		end else begin
			ok = ok && a_cols == b_rows;
		end
		return ok;
	endfunction

	function automatic result_word_t error_word();
		result_word_t w;
		w.value = '0;
		w.row = '0;
		w.col = '0;
		w.last = 1'b1;
		w.err = 1'b1;
		return w;
	endfunction

	// Works out every word of a run in row-major order. Sums and products are kept at 32 bits,
	// so they wrap exactly as the engine's do.
	task automatic predict_run();
		int out_rows;
		int out_cols;
		logic [VAL_W-1:0] acc;
		result_word_t w;
		if (!dims_fit()) begin
			expected_words.push_back(error_word());
			return;
		end
		out_rows = int'(a_rows);
		out_cols = (eng_mode == MODE_ADD) ? int'(a_cols) : int'(b_cols);
		for (int i = 0; i < out_rows; i++) begin
			for (int j = 0; j < out_cols; j++) begin
				if (eng_mode == MODE_ADD) begin
					acc = store_a[i*MAX_DIM + j] + store_b[i*MAX_DIM + j];
				end else begin
					acc = '0;
					for (int k = 0; k < int'(a_cols); k++) begin
						acc = acc + store_a[i*MAX_DIM + k] * store_b[k*MAX_DIM + j];
					end
				end
				w.value = acc;
				w.row = 3'(i);
				w.col = 3'(j);
				w.last = (i == out_rows - 1) && (j == out_cols - 1);
				w.err = 1'b0;
				expected_words.push_back(w);
			end
		end
	endtask

	// Brings the predictor up to date with a word the engine has just taken.
	task automatic model_word(input logic [1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value, input bit typed_err);
		case (op)
			OP_WRITE_A: begin
				store_a[{row, col}] = value;
				a_written[{row, col}] = 1'b1;
			end
			OP_WRITE_B: begin
				store_b[{row, col}] = value;
				b_written[{row, col}] = 1'b1;
			end
			OP_RUN: begin
				if (typed_err) begin
					expected_words.push_back(error_word());
				end else begin
					predict_run();
				end
			end
			default: begin
			end
		endcase
		if (op != OP_UNUSED) begin
			items_sent++;
		end
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'(int'($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	// Offers one word on the input stream and returns once the engine has taken it. Idle
	// cycles are drawn at the falling edge, before the word is raised, so a word held over
	// from the previous call is never dropped and raised in the same step.
	task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value, input bit typed_err);
		calm = items_sent >= 100 && items_sent < 150;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 40'({$urandom, $urandom});
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {value, col, row, op};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		model_word(op, row, col, value, typed_err);
	endtask

	// Before a run that will read the stores, every entry it needs is loaded if it never was.
	// When the dimensions fit, B's used block is rows_b by cols_b in either mode.
	task automatic send_run(input bit typed_err);
		if (dims_fit()) begin
			for (int i = 0; i < MAX_DIM; i++) begin
				for (int j = 0; j < MAX_DIM; j++) begin
					if (i < int'(a_rows) && j < int'(a_cols) && !a_written[i*MAX_DIM + j]) begin
						send_word(OP_WRITE_A, 3'(i), 3'(j), rand_value(), 1'b0);
					end
					if (i < int'(b_rows) && j < int'(b_cols) && !b_written[i*MAX_DIM + j]) begin
						send_word(OP_WRITE_B, 3'(i), 3'(j), rand_value(), 1'b0);
					end
				end
			end
		end
		send_word(OP_RUN, 3'($urandom), 3'($urandom), $urandom, typed_err);
	endtask

	// Drops the input stream and waits until every expected word has arrived, then a little
	// longer so that a trailing write has surely been taken in.
	task automatic wait_drain(input int settle);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [DIM_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_MODE:   eng_mode = data[0];
			CFG_ROWS_A: a_rows = data;
			CFG_COLS_A: a_cols = data;
			CFG_ROWS_B: b_rows = data;
			CFG_COLS_B: b_cols = data;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A whole setting at once, taken while the engine is idle. The mode write carries random
	// upper bits, which the engine must ignore.
	task automatic set_dims(input logic md, input logic [DIM_W-1:0] ra,
			input logic [DIM_W-1:0] ca, input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
		wait_drain(SETTLE_CYCLES);
		cfg_write(CFG_MODE, {3'($urandom), md});
		cfg_write(CFG_ROWS_A, ra);
		cfg_write(CFG_COLS_A, ca);
		cfg_write(CFG_ROWS_B, rb);
		cfg_write(CFG_COLS_B, cb);
	endtask

	task automatic add_word(input logic [1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value, input bit typed_err);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_idx = '0;
		r.cfg_val = '0;
		r.op = op;
		r.row = row;
		r.col = col;
		r.value = value;
		r.typed_err = typed_err;
		directed_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [CFG_AW-1:0] idx, input logic [DIM_W-1:0] data);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = data;
		r.op = OP_UNUSED;
		r.row = '0;
		r.col = '0;
		r.value = '0;
		r.typed_err = 1'b0;
		directed_rows.push_back(r);
	endtask

	// Highest index worth writing for a dimension: inside the used block when the register is
	// in range, anywhere otherwise.
	function automatic int span(input logic [DIM_W-1:0] d);
		return dim_in_range(d) ? int'(d) - 1 : MAX_DIM - 1;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 4'd8;
		end else if (r < 20) begin
			return 4'($urandom_range(1, MAX_DIM));
		end
		return 4'($urandom_range(1, 3));
	endfunction

	// One random phase: a setting, a few loads and some noise, a run, then words offered
	// straight behind the run so that they queue up against the busy engine.
	task automatic random_phase(input int phase);
		logic             md;
		logic [DIM_W-1:0] ra;
		logic [DIM_W-1:0] ca;
		logic [DIM_W-1:0] rb;
		logic [DIM_W-1:0] cb;
		logic [DIM_W-1:0] bad;
		int               r;
		int               n_pre;
		int               n_post;
		case (phase)
			// The extremes first: a full-height column times a full-width row, the
			// reverse with an eight-term sum, and a full-height addition.
			0: begin md = MODE_MUL; ra = 4'd8; ca = 4'd1; rb = 4'd1; cb = 4'd8; end
			1: begin md = MODE_MUL; ra = 4'd1; ca = 4'd8; rb = 4'd8; cb = 4'd1; end
			2: begin md = MODE_ADD; ra = 4'd8; ca = 4'd1; rb = 4'd8; cb = 4'd1; end
			default: begin
				md = 1'($urandom);
				ra = pick_dim();
				ca = pick_dim();
				cb = pick_dim();
				rb = (md == MODE_ADD) ? ra : ca;
				if (md == MODE_ADD) begin
					cb = ca;
				end
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// A fitting setting pushed out of step by one register.
					if (md == MODE_ADD && $urandom_range(0, 1) == 0) begin
						cb = 4'(ca % MAX_DIM + 1);
					end else begin
						rb = 4'(rb % MAX_DIM + 1);
					end
				end else if (r < 23) begin
					// Zero or above the largest size, in any one register.
					bad = 4'($urandom_range(0, 7));
					bad = (bad == 0) ? 4'd0 : bad + 4'd8;
					case ($urandom_range(0, 3))
						0: ra = bad;
						1: ca = bad;
						2: rb = bad;
						default: cb = bad;
					endcase
				end
			end
		endcase
		set_dims(md, ra, ca, rb, cb);

		n_pre = $urandom_range(0, 6);
		for (int n = 0; n < n_pre; n++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_word(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom, 1'b0);
			end else if (r < 40) begin
				send_word(OP_WRITE_A, 3'($urandom_range(0, span(ra))),
					3'($urandom_range(0, span(ca))), rand_value(), 1'b0);
			end else if (r < 70) begin
				send_word(OP_WRITE_B, 3'($urandom_range(0, span(rb))),
					3'($urandom_range(0, span(cb))), rand_value(), 1'b0);
			end else begin
				send_word(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
					rand_value(), 1'b0);
			end
		end
		send_run(1'b0);

		n_post = (phase < 3) ? 3 : $urandom_range(0, 3);
		for (int n = 0; n < n_post; n++) begin
			send_word(2'($urandom_range(0, 1)), 3'($urandom_range(0, span(ra))),
				3'($urandom_range(0, span(ca))), rand_value(), 1'b0);
		end
		if ($urandom_range(0, 99) < 30) begin
			send_run(1'b0);
		end
	endtask

	// Receiver: draws tready at the falling edge. Once, while a run still has several words
	// to deliver, it holds off for a long stretch so that the output register fills and the
	// engine stops taking input words.
	always @(negedge clk) begin
		if (!hold_used && results_seen >= 20 && expected_words.size() >= 4) begin
			hold_used = 1'b1;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || $urandom_range(0, 99) >= 15;
		end
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Every word taken from the output stream is held against the oldest expectation.
	always @(posedge clk) begin : rx_check
		result_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got value %h row %0d col %0d last %b err %b",
					$time, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[37:35],
					m_axis_tlast, m_axis_tuser);
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("result_value", want.value, m_axis_tdata[31:0]);
				check_field("result_row", 32'(want.row), 32'(m_axis_tdata[34:32]));
				check_field("result_col", 32'(want.col), 32'(m_axis_tdata[37:35]));
				check_field("last", 32'(want.last), 32'(m_axis_tlast));
				check_field("dim_error", 32'(want.err), 32'(m_axis_tuser));
			end
		end
	end

	initial begin
		int phase;
		for (int e = 0; e < MAX_DIM*MAX_DIM; e++) begin
			store_a[e] = '0;
			store_b[e] = '0;
			a_written[e] = 1'b0;
			b_written[e] = 1'b0;
		end

		// Directed table. The reset setting is a one by one product; the largest values
		// square and wrap, the dropped code is tried at the top corner, and each kind of
		// unsuitable setting gives the error word, which is typed in here.
		add_word(OP_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0);
		add_word(OP_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b0);
		add_word(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0);
		add_word(OP_WRITE_A, 3'd7, 3'd7, 32'h8000_0000, 1'b0);
		add_word(OP_WRITE_B, 3'd7, 3'd7, 32'h8000_0000, 1'b0);
		add_cfg(CFG_ROWS_A, 4'd0);
		add_word(OP_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1);
		add_cfg(CFG_ROWS_A, 4'd15);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b1);
		add_cfg(CFG_ROWS_A, 4'd1);
		add_cfg(CFG_COLS_B, 4'd9);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b1);
		// Addition with the column counts out of step.
		add_cfg(CFG_MODE, {3'b000, MODE_ADD});
		add_cfg(CFG_COLS_B, 4'd2);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b1);
		add_cfg(CFG_COLS_B, 4'd1);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b0);
		add_word(OP_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0);
		add_word(OP_WRITE_B, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b0);
		// Product with the inner sizes out of step, then put right.
		add_cfg(CFG_MODE, {3'b111, MODE_MUL});
		add_cfg(CFG_COLS_A, 4'd2);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b1);
		add_cfg(CFG_ROWS_B, 4'd2);
		add_word(OP_WRITE_A, 3'd0, 3'd1, 32'h0000_0003, 1'b0);
		add_word(OP_WRITE_B, 3'd1, 3'd0, 32'hFFFF_FFFD, 1'b0);
		add_word(OP_RUN, 3'd0, 3'd0, 32'h0000_0000, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].is_cfg) begin
				wait_drain(SETTLE_CYCLES);
				cfg_write(directed_rows[n].cfg_idx, directed_rows[n].cfg_val);
			end else if (directed_rows[n].op == OP_RUN) begin
				send_run(directed_rows[n].typed_err);
			end else begin
				send_word(directed_rows[n].op, directed_rows[n].row, directed_rows[n].col,
					directed_rows[n].value, 1'b0);
			end
		end

		// Random phases until enough words have gone in and enough results come back.
		phase = 0;
		while (items_sent < 230 || results_seen < 48) begin
			random_phase(phase);
			phase++;
		end

		wait_drain(TAIL_CYCLES);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// The simulation finishes long before this limit, even with every run at full size.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
